>>> rtl/core/vlrs_pkg.sv
`timescale 1ns / 1ps

package vlrs_pkg;

    localparam int DEPTH     = 4096;
    localparam int MAX_ELEM  = 64;
    localparam int HDR_BYTES = 4;

    localparam int AW    = $clog2(DEPTH);
    localparam int CAP_W = $clog2(DEPTH + 1);
    localparam int LEN_W = 7;
    localparam int HC_W  = $clog2(HDR_BYTES + 1);
    // wide enough for top + header + stored length and for header + elem_len
    localparam int SW    = ((AW > 8) ? AW : 8) + 1;

    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_PEEK  = 2'd2,
        FN_CHECK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef struct packed {
        t_func            func;
        logic [LEN_W-1:0] elem_len;
        logic [7:0]       data_byte;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       is_empty;
        logic       fits;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_emit;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

    function automatic logic f_fits(logic [AW-1:0] top, logic [LEN_W-1:0] len);
        logic [SW-1:0] need;
        need = SW'(HDR_BYTES) + SW'(len);
        return SW'(top) >= need;
    endfunction

    function automatic t_res f_res(t_status st, logic [7:0] b, logic bv, logic lst,
                                   logic [AW-1:0] top, logic [CAP_W-1:0] cap,
                                   logic [LEN_W-1:0] len);
        t_res r;
        r.status     = st;
        r.out_byte   = b;
        r.byte_valid = bv;
        r.last       = lst;
        r.is_empty   = (SW'(top) == (SW'(cap) - SW'(1)));
        r.fits       = f_fits(top, len);
        return r;
    endfunction

endpackage

>>> rtl/core/vlrs_ram.sv
`timescale 1ns / 1ps

module vlrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/vlrs_ctrl.sv
`timescale 1ns / 1ps

module vlrs_ctrl
    import vlrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic [7:0]       i_rdata,
    output logic             o_busy,
    output t_mem_req         o_mem,
    output t_emit            o_emit
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HDR    = 4'b0010,
        S_RDHDR  = 4'b0100,
        S_STREAM = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CAP_W-1:0] r_cap,   n_cap;
    logic [AW-1:0]    r_top,   n_top;
    logic [LEN_W-1:0] r_pcnt,  n_pcnt;
    logic [LEN_W-1:0] r_plen,  n_plen;
    logic             r_pdrop, n_pdrop;
    // per-item working registers
    logic [HC_W-1:0]  r_hcnt,  n_hcnt;
    logic [AW-1:0]    r_base,  n_base;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [7:0]       r_byte,  n_byte;
    t_func            r_func,  n_func;
    logic [LEN_W-1:0] r_k,     n_k;
    logic [LEN_W-1:0] r_idx,   n_idx;
    logic [AW-1:0]    r_ptr,   n_ptr;

    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] kk;
    logic [SW-1:0]    nt;
    logic [SW-1:0]    lim;
    logic [CAP_W-1:0] cap_sat;
    t_status          st;

    always_comb begin
        n_state = r_state;
        n_cap   = r_cap;
        n_top   = r_top;
        n_pcnt  = r_pcnt;
        n_plen  = r_plen;
        n_pdrop = r_pdrop;
        n_hcnt  = r_hcnt;
        n_base  = r_base;
        n_len   = r_len;
        n_byte  = r_byte;
        n_func  = r_func;
        n_k     = r_k;
        n_idx   = r_idx;
        n_ptr   = r_ptr;
        o_mem   = '0;
        o_emit  = '0;
        limit   = (r_len > LEN_W'(MAX_ELEM)) ? LEN_W'(MAX_ELEM) : r_len;
        kk      = ({1'b0, limit} < i_rdata) ? limit : LEN_W'(i_rdata);
        nt      = SW'(r_top) + SW'(HDR_BYTES) + SW'(i_rdata);
        lim     = SW'(r_cap) - SW'(1);
        cap_sat = i_cfg_data;
        st      = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_len = i_cmd.elem_len;
                    if (i_cmd.func != FN_PUSH) begin
                        // a non-push item abandons a partly pushed element
                        n_pcnt  = '0;
                        n_plen  = '0;
                        n_pdrop = 1'b0;
                    end
                    unique case (i_cmd.func)
                        FN_PUSH: begin
                            if (r_pcnt == '0) begin
                                if (i_cmd.elem_len > LEN_W'(MAX_ELEM) ||
                                    !f_fits(r_top, i_cmd.elem_len)) begin
                                    st = ST_NO_ROOM;
                                    if (i_cmd.elem_len > LEN_W'(1)) begin
                                        n_pdrop = 1'b1;
                                        n_plen  = i_cmd.elem_len;
                                        n_pcnt  = LEN_W'(1);
                                    end
                                end else begin
                                    n_base  = AW'(r_top - AW'(i_cmd.elem_len)
                                                  - AW'(HDR_BYTES));
                                    n_hcnt  = '0;
                                    n_byte  = i_cmd.data_byte;
                                    n_state = S_HDR;
                                    if (i_cmd.elem_len == '0) begin
                                        n_top = AW'(r_top - AW'(HDR_BYTES));
                                    end else if (i_cmd.elem_len == LEN_W'(1)) begin
                                        n_top = AW'(r_top - AW'(HDR_BYTES + 1));
                                    end else begin
                                        n_plen = i_cmd.elem_len;
                                        n_pcnt = LEN_W'(1);
                                    end
                                end
                            end else begin
                                if (r_pdrop) begin
                                    st = ST_NO_ROOM;
                                end else begin
                                    o_mem.we    = 1'b1;
                                    o_mem.waddr = AW'(r_top - AW'(r_plen) + AW'(r_pcnt));
                                    o_mem.wdata = i_cmd.data_byte;
                                end
                                n_pcnt = r_pcnt + LEN_W'(1);
                                if (n_pcnt >= r_plen) begin
                                    if (!r_pdrop) begin
                                        n_top = AW'(r_top - AW'(HDR_BYTES) - AW'(r_plen));
                                    end
                                    n_pcnt  = '0;
                                    n_plen  = '0;
                                    n_pdrop = 1'b0;
                                end
                            end
                            o_emit.valid = 1'b1;
                            o_emit.res   = f_res(st, 8'd0, 1'b0, 1'b1, n_top, r_cap,
                                                 i_cmd.elem_len);
                        end
                        FN_CHECK: begin
                            o_emit.valid = 1'b1;
                            o_emit.res   = f_res(ST_OK, 8'd0, 1'b0, 1'b1, r_top, r_cap,
                                                 i_cmd.elem_len);
                        end
                        FN_POP, FN_PEEK: begin
                            if (SW'(r_top) == lim) begin
                                o_emit.valid = 1'b1;
                                o_emit.res   = f_res(ST_EMPTY, 8'd0, 1'b0, 1'b1, r_top,
                                                     r_cap, i_cmd.elem_len);
                            end else begin
                                // length byte is the low header byte at top
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_top;
                                n_func      = i_cmd.func;
                                n_state     = S_RDHDR;
                            end
                        end
                    endcase
                end
            end
            S_HDR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = AW'(r_base + AW'(r_hcnt));
                if (r_hcnt == '0) begin
                    o_mem.wdata = 8'(r_len);
                end else if (r_hcnt == HC_W'(HDR_BYTES)) begin
                    o_mem.wdata = r_byte;
                end else begin
                    o_mem.wdata = 8'd0;
                end
                if ((r_len == '0 && r_hcnt == HC_W'(HDR_BYTES - 1)) ||
                    r_hcnt == HC_W'(HDR_BYTES)) begin
                    n_state = S_IDLE;
                end else begin
                    n_hcnt = r_hcnt + HC_W'(1);
                end
            end
            S_RDHDR: begin
                if (r_func == FN_POP) begin
                    n_top = (nt > lim) ? AW'(lim) : AW'(nt);
                end
                if (kk == '0) begin
                    o_emit.valid = 1'b1;
                    o_emit.res   = f_res(ST_OK, 8'd0, 1'b0, 1'b1, n_top, r_cap, r_len);
                    n_state      = S_IDLE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = AW'(r_top + AW'(HDR_BYTES));
                    n_ptr       = AW'(r_top + AW'(HDR_BYTES + 1));
                    n_k         = kk;
                    n_idx       = '0;
                    n_state     = S_STREAM;
                end
            end
            S_STREAM: begin
                o_emit.valid = 1'b1;
                o_emit.res   = f_res(ST_OK, i_rdata, 1'b1, (r_idx + LEN_W'(1)) == r_k,
                                     r_top, r_cap, r_len);
                if ((r_idx + LEN_W'(1)) == r_k) begin
                    n_state = S_IDLE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_ptr;
                    n_ptr       = r_ptr + AW'(1);
                    n_idx       = r_idx + LEN_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write: saturate to 1..DEPTH and empty the stack
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                cap_sat = CAP_W'(1);
            end else if (i_cfg_data > CAP_W'(DEPTH)) begin
                cap_sat = CAP_W'(DEPTH);
            end
            n_cap   = cap_sat;
            n_top   = AW'(cap_sat - CAP_W'(1));
            n_pcnt  = '0;
            n_plen  = '0;
            n_pdrop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_W'(DEPTH);
            r_top   <= AW'(DEPTH - 1);
            r_pcnt  <= '0;
            r_plen  <= '0;
            r_pdrop <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_top   <= n_top;
            r_pcnt  <= n_pcnt;
            r_plen  <= n_plen;
            r_pdrop <= n_pdrop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hcnt <= n_hcnt;
        r_base <= n_base;
        r_len  <= n_len;
        r_byte <= n_byte;
        r_func <= n_func;
        r_k    <= n_k;
        r_idx  <= n_idx;
        r_ptr  <= n_ptr;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/core/variable_length_record_stack.sv
`timescale 1ns / 1ps
// Timing: push/check and empty pop/peek answer in the cycle after acceptance; other
//   pop/peek read the header, then S_RDHDR (k = 0) or S_STREAM (k bytes out) emits.
// Busy: S_HDR writes the HDR_BYTES header bytes and any data byte of a push first byte;
//   S_RDHDR and S_STREAM serve pop/peek; other items leave busy low.
// No backpressure: every result beat is taken. Reset (i_rst_n low, sync): capacity =
//   DEPTH, stack empty, no push in progress; the RAM is not cleared.
module variable_length_record_stack
    import vlrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_cmd             i_cmd,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_res             o_res
);

    t_mem_req   mem;
    t_emit      emit;
    logic [7:0] rdata;

    // result beat register; the receiver takes every beat, so no skid needed
    logic r_valid;
    t_res r_res;

    // sequencer: stack pointer, push tracking, header and stream walks
    vlrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rdata    (rdata),
        .o_busy     (busy),
        .o_mem      (mem),
        .o_emit     (emit)
    );

    // byte store, one write and one registered read per cycle
    vlrs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= emit.res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/core/vlrs_chk.sv
`timescale 1ns / 1ps

module vlrs_chk
    import vlrs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_cmd i_cmd,
    input logic o_valid,
    input t_res o_res
);

    // push and check answer with a single beat on the next cycle
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.func == FN_PUSH || i_cmd.func == FN_CHECK)
        |=> o_valid && o_res.last)
        else $error("push/check did not answer with one last beat");

    a_nodata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.byte_valid |-> o_res.last)
        else $error("beat without data is not last");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.byte_valid |-> o_res.status == ST_OK)
        else $error("data beat with error status");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status == ST_EMPTY |-> o_res.is_empty && !o_res.byte_valid)
        else $error("empty status on non-empty stack");

    // a pop/peek stream has no gaps
    a_stream_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.byte_valid && !o_res.last |=> o_valid && o_res.byte_valid)
        else $error("gap inside data stream");

endmodule

bind variable_length_record_stack vlrs_chk u_vlrs_chk (.*);
